>>> src/ntlb_pkg.sv
// ntlb_pkg: payload, configuration and pipeline types shared by the NTT butterfly unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ntlb_pkg;

  // butterfly selector codes; the last one has no butterfly and answers zeros
  typedef enum logic [1:0] {
    MODE_FWD       = 2'd0,
    MODE_INV       = 2'd1,
    MODE_INV_FINAL = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS              = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N                = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_PRECON         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_TWIDDLE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_TWIDDLE_PRECON = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [33:0] x_in;
    logic [33:0] y_in;
    logic [31:0] twiddle;
    logic [31:0] twiddle_precon;
  } req_t;

  typedef struct packed {
    logic [63:0] x_out;
    logic [63:0] y_out;
  } rsp_t;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] inv_n;
    logic [31:0] inv_n_precon;
    logic [31:0] inv_n_twiddle;
    logic [31:0] inv_n_twiddle_precon;
  } cfg_regs_t;

  // one Shoup product: val * fac - ((pre * val) >> 32) * q, mod 2^64
  typedef struct packed {
    logic [63:0] val;
    logic [31:0] fac;
    logic [31:0] pre;
  } lane_op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] aux;
    lane_op_t    lane_x;
    lane_op_t    lane_y;
  } pre_t;

  // load enables of the four product stages
  typedef struct packed {
    logic pp;
    logic sum;
    logic quot;
    logic res;
  } mul_en_t;

endpackage

>>> src/ntlb_pre.sv
// ntlb_pre: first stage; operand conditioning and product lane set-up.
// Depends on ntlb_pkg.
`timescale 1ns / 1ps

module ntlb_pre (
  input  logic               clk,
  input  logic               en,
  input  ntlb_pkg::req_t     req_i,
  input  ntlb_pkg::cfg_regs_t cfg_i,
  output ntlb_pkg::pre_t     pre_o
);

  ntlb_pkg::pre_t pre_r, pre_nxt;
  logic [63:0] q2, x64, y64, xy, xy_red, x_red, t_diff;

  always_comb begin
    q2     = {31'd0, cfg_i.modulus, 1'b0};
    x64    = {30'd0, req_i.x_in};
    y64    = {30'd0, req_i.y_in};
    xy     = x64 + y64;
    // x + y stays below 2^35, so the sign test of x + y - 2q is a plain compare
    xy_red = (xy >= q2) ? xy - q2 : xy;
    x_red  = (x64 >= q2) ? x64 - q2 : x64;
    t_diff = x64 - y64 + q2;

    pre_nxt.mode       = req_i.req_type;
    pre_nxt.aux        = '0;
    pre_nxt.lane_x.val = xy_red;
    pre_nxt.lane_x.fac = cfg_i.inv_n;
    pre_nxt.lane_x.pre = cfg_i.inv_n_precon;
    pre_nxt.lane_y.val = y64;
    pre_nxt.lane_y.fac = req_i.twiddle;
    pre_nxt.lane_y.pre = req_i.twiddle_precon;

    unique case (req_i.req_type)
      ntlb_pkg::MODE_FWD: begin
        pre_nxt.aux = x_red;
      end
      ntlb_pkg::MODE_INV: begin
        pre_nxt.aux        = xy_red;
        pre_nxt.lane_y.val = t_diff;
      end
      ntlb_pkg::MODE_INV_FINAL: begin
        pre_nxt.lane_y.val = t_diff;
        pre_nxt.lane_y.fac = cfg_i.inv_n_twiddle;
        pre_nxt.lane_y.pre = cfg_i.inv_n_twiddle_precon;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign pre_o = pre_r;

endmodule

>>> src/ntlb_mul.sv
// ntlb_mul: four-stage Shoup modular product lane, wrapping mod 2^64.
// Depends on ntlb_pkg.
`timescale 1ns / 1ps

module ntlb_mul (
  input  logic               clk,
  input  ntlb_pkg::mul_en_t  en,
  input  ntlb_pkg::lane_op_t op_i,
  input  logic [31:0]        q_i,
  output logic [63:0]        res_o
);

  logic [63:0] p_lo_r, p_lo_nxt, f_lo_r, f_lo_nxt;
  logic [31:0] p_hi_r, p_hi_nxt, f_hi_r, f_hi_nxt;
  logic [63:0] p_hi_full, f_hi_full, p_sum;
  logic [31:0] quot_r, quot_nxt;
  logic [63:0] fv_r, fv_nxt, fv2_r;
  logic [63:0] qq_r, qq_nxt;
  logic [63:0] res_r, res_nxt;

  // partial products; the upper operand half only feeds the low word
  always_comb begin
    p_lo_nxt  = {32'd0, op_i.pre} * {32'd0, op_i.val[31:0]};
    p_hi_full = {32'd0, op_i.pre} * {32'd0, op_i.val[63:32]};
    p_hi_nxt  = p_hi_full[31:0];
    f_lo_nxt  = {32'd0, op_i.fac} * {32'd0, op_i.val[31:0]};
    f_hi_full = {32'd0, op_i.fac} * {32'd0, op_i.val[63:32]};
    f_hi_nxt  = f_hi_full[31:0];
  end

  always_comb begin
    p_sum    = p_lo_r + {p_hi_r, 32'd0};
    quot_nxt = p_sum[63:32];
    fv_nxt   = f_lo_r + {f_hi_r, 32'd0};
    qq_nxt   = {32'd0, quot_r} * {32'd0, q_i};
    res_nxt  = fv2_r - qq_r;
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      f_lo_r <= f_lo_nxt;
      f_hi_r <= f_hi_nxt;
    end
    if (en.sum) begin
      quot_r <= quot_nxt;
      fv_r   <= fv_nxt;
    end
    if (en.quot) begin
      qq_r  <= qq_nxt;
      fv2_r <= fv_r;
    end
    if (en.res) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

>>> src/ntlb_post.sv
// ntlb_post: last stage; butterfly recombination and final reduction into the output register.
// Depends on ntlb_pkg.
`timescale 1ns / 1ps

module ntlb_post (
  input  logic           clk,
  input  logic           en,
  input  logic [1:0]     mode_i,
  input  logic [63:0]    aux_i,
  input  logic [63:0]    rx_i,
  input  logic [63:0]    ry_i,
  input  logic [31:0]    q_i,
  output ntlb_pkg::rsp_t rsp_o
);

  ntlb_pkg::rsp_t rsp_r, rsp_nxt;
  logic [63:0] q64, q2;

  always_comb begin
    q64     = {32'd0, q_i};
    q2      = {31'd0, q_i, 1'b0};
    rsp_nxt = '0;
    unique case (mode_i)
      ntlb_pkg::MODE_FWD: begin
        rsp_nxt.x_out = aux_i + ry_i;
        rsp_nxt.y_out = aux_i + q2 - ry_i;
      end
      ntlb_pkg::MODE_INV: begin
        rsp_nxt.x_out = aux_i;
        rsp_nxt.y_out = ry_i;
      end
      ntlb_pkg::MODE_INV_FINAL: begin
        // min(v, v - q) in unsigned terms
        rsp_nxt.x_out = (rx_i >= q64) ? rx_i - q64 : rx_i;
        rsp_nxt.y_out = (ry_i >= q64) ? ry_i - q64 : ry_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp_o = rsp_r;

endmodule

>>> src/ntt_lazy_butterfly_unit.sv
// ntt_lazy_butterfly_unit: top level of the lazy NTT butterfly pipeline.
// Depends on ntlb_pkg, ntlb_pre, ntlb_mul, ntlb_post.
`timescale 1ns / 1ps

// Usage
//  - in_*: one butterfly request per beat (mode, x, y, twiddle, twiddle quotient).
//  - out_*: one result beat per request, in request order.
//  - cfg_*: register writes (modulus, n^-1 and n^-1*w with their quotients);
//    cfg_ready is always high. Write only while the pipeline is empty.
//  - Six register stages: conditioning, partial products, product sums,
//    quotient times q, subtraction, recombination/output register.
//    out_valid is the valid bit of the output register.
//  - Throughput is one beat per cycle unless out_ready holds the output;
//    the multiplier stages set the depth.
//  - Each stage carries its own valid bit and takes a new beat whenever it is
//    empty or its successor moves, so bubbles close up under back-pressure.
//  - When out_ready is low the output register holds its beat; the stages
//    behind it keep filling until all six are full, then in_ready drops.
//  - rst_n (synchronous, active low) empties the pipeline and clears all
//    configuration registers to zero.

module ntt_lazy_butterfly_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ntlb_pkg::req_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ntlb_pkg::rsp_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ntlb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);

  ntlb_pkg::cfg_regs_t cfg_r;
  logic [6:1] valid_r;
  logic [7:1] rdy;
  ntlb_pkg::pre_t  pre;
  ntlb_pkg::mul_en_t mul_en;
  logic [1:0]  mode_r [2:5];
  logic [63:0] aux_r  [2:5];
  logic [63:0] res_x, res_y;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ntlb_pkg::CFG_MODULUS:              cfg_r.modulus              <= cfg_data;
        ntlb_pkg::CFG_INV_N:                cfg_r.inv_n                <= cfg_data;
        ntlb_pkg::CFG_INV_N_PRECON:         cfg_r.inv_n_precon         <= cfg_data;
        ntlb_pkg::CFG_INV_N_TWIDDLE:        cfg_r.inv_n_twiddle        <= cfg_data;
        ntlb_pkg::CFG_INV_N_TWIDDLE_PRECON: cfg_r.inv_n_twiddle_precon <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when empty or when its own beat moves on
  always_comb begin
    rdy[7] = out_ready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[1]) valid_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // mode and pass-through operand travel beside the product lanes
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mode_r[2] <= pre.mode;
      aux_r[2]  <= pre.aux;
    end
    for (int k = 3; k <= 5; k++) begin
      if (rdy[k]) begin
        mode_r[k] <= mode_r[k-1];
        aux_r[k]  <= aux_r[k-1];
      end
    end
  end

  assign mul_en.pp   = rdy[2];
  assign mul_en.sum  = rdy[3];
  assign mul_en.quot = rdy[4];
  assign mul_en.res  = rdy[5];

  ntlb_pre u_pre (
    .clk   (clk),
    .en    (rdy[1]),
    .req_i (in_data),
    .cfg_i (cfg_r),
    .pre_o (pre)
  );

  // lane x: n^-1 scaling of the sum (final inverse stage only)
  ntlb_mul u_mul_x (
    .clk   (clk),
    .en    (mul_en),
    .op_i  (pre.lane_x),
    .q_i   (cfg_r.modulus),
    .res_o (res_x)
  );

  // lane y: twiddle product (or n^-1*w in the final inverse stage)
  ntlb_mul u_mul_y (
    .clk   (clk),
    .en    (mul_en),
    .op_i  (pre.lane_y),
    .q_i   (cfg_r.modulus),
    .res_o (res_y)
  );

  ntlb_post u_post (
    .clk    (clk),
    .en     (rdy[6]),
    .mode_i (mode_r[5]),
    .aux_i  (aux_r[5]),
    .rx_i   (res_x),
    .ry_i   (res_y),
    .q_i    (cfg_r.modulus),
    .rsp_o  (out_data)
  );

  assign in_ready  = rdy[1];
  assign out_valid = valid_r[6];

endmodule

>>> src/ntlb_checker.sv
// ntlb_checker: port-level assertions for ntt_lazy_butterfly_unit, with its bind.
// Depends on ntlb_pkg.
`timescale 1ns / 1ps

module ntlb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ntlb_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ntlb_pkg::rsp_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a free output lets every stage move, so the input is open
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

  // unused selector gives a zero beat when nothing stalls
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == ntlb_pkg::MODE_UNUSED)
      ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid && out_data.x_out == 64'd0 && out_data.y_out == 64'd0)
    else $error("unused selector gave a non-zero result");

endmodule

bind ntt_lazy_butterfly_unit ntlb_checker u_ntlb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> dv/ntt_lazy_butterfly_unit_tb.sv
// ntt_lazy_butterfly_unit_tb: self-checking bench for the lazy NTT butterfly unit.
// Drives request, result and register channels; predicts every result in-bench.
// Depends on ntlb_pkg and ntt_lazy_butterfly_unit.
`timescale 1ns / 1ps

module ntt_lazy_butterfly_unit_tb;

  // register index outside the map; writes to it are dropped
  localparam logic [ntlb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam int unsigned LATENCY     = 6;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [33:0] X_MAX       = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ntlb_pkg::req_t      in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ntlb_pkg::rsp_t      out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ntlb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  ntlb_pkg::cfg_regs_t model_cfg = '0;   // shadow of the block's registers
  ntlb_pkg::rsp_t      pending_rsp[$];   // predicted results, oldest first
  int unsigned         err_count = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         hold_requests = 0;

  always #5 clk = ~clk;

  ntt_lazy_butterfly_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // value * fac - ((pre * value) >> 32) * q, every step mod 2^64
  function automatic logic [63:0] shoup_mul_mod(logic [63:0] value, logic [31:0] fac,
                                                logic [31:0] pre, logic [31:0] q);
    logic [63:0] quot;
    quot = ({32'd0, pre} * value) >> 32;
    return {32'd0, fac} * value + quot * (64'd0 - {32'd0, q});
  endfunction

  function automatic logic [63:0] min_u64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // floor(v * 2^32 / q), the quotient factor for a well-formed operand
  function automatic logic [31:0] quot_factor(logic [31:0] v, logic [31:0] q);
    if (q == 0) return '0;
    return 32'({v, 32'd0} / {32'd0, q});
  endfunction

  function automatic ntlb_pkg::rsp_t butterfly_predict(ntlb_pkg::req_t r);
    ntlb_pkg::rsp_t res;
    logic [63:0]    q, q2, x, y, d, t, s;
    q   = {32'd0, model_cfg.modulus};
    q2  = q << 1;
    x   = {30'd0, r.x_in};
    y   = {30'd0, r.y_in};
    res = '0;
    case (r.req_type)
      ntlb_pkg::MODE_FWD: begin
        // Cooley-Tukey: condition x below 2q, then x +/- w*y
        x = min_u64(x, x - q2);
        t = shoup_mul_mod(y, r.twiddle, r.twiddle_precon, model_cfg.modulus);
        res.y_out = x + (q2 - t);
        res.x_out = x + t;
      end
      ntlb_pkg::MODE_INV: begin
        // Gentleman-Sande: sum corrected on sign, difference times w
        d = y - q2;
        t = x - d;
        s = x + d;
        if (s[63]) s = s + q2;
        res.x_out = s;
        res.y_out = shoup_mul_mod(t, r.twiddle, r.twiddle_precon, model_cfg.modulus);
      end
      ntlb_pkg::MODE_INV_FINAL: begin
        // last inverse stage: scale by n^-1 and n^-1*w, full reduction
        d = y - q2;
        t = x - d;
        s = x + y;
        s = min_u64(s, s - q2);
        res.x_out = shoup_mul_mod(s, model_cfg.inv_n, model_cfg.inv_n_precon,
                                  model_cfg.modulus);
        res.y_out = shoup_mul_mod(t, model_cfg.inv_n_twiddle,
                                  model_cfg.inv_n_twiddle_precon, model_cfg.modulus);
        res.x_out = min_u64(res.x_out, res.x_out - q);
        res.y_out = min_u64(res.y_out, res.y_out - q);
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // one request beat; leaves in_valid high so back-to-back beats need no dip
  task automatic send_req(ntlb_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(butterfly_predict(r));
  endtask

  task automatic cfg_write(logic [ntlb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ntlb_pkg::CFG_MODULUS:              model_cfg.modulus              = value;
      ntlb_pkg::CFG_INV_N:                model_cfg.inv_n                = value;
      ntlb_pkg::CFG_INV_N_PRECON:         model_cfg.inv_n_precon         = value;
      ntlb_pkg::CFG_INV_N_TWIDDLE:        model_cfg.inv_n_twiddle        = value;
      ntlb_pkg::CFG_INV_N_TWIDDLE_PRECON: model_cfg.inv_n_twiddle_precon = value;
      default: ;
    endcase
  endtask

  // full register set plus one write to an unmapped index
  task automatic apply_config(ntlb_pkg::cfg_regs_t c);
    cfg_write(ntlb_pkg::CFG_MODULUS,              c.modulus);
    cfg_write(ntlb_pkg::CFG_INV_N,                c.inv_n);
    cfg_write(ntlb_pkg::CFG_INV_N_PRECON,         c.inv_n_precon);
    cfg_write(ntlb_pkg::CFG_INV_N_TWIDDLE,        c.inv_n_twiddle);
    cfg_write(ntlb_pkg::CFG_INV_N_TWIDDLE_PRECON, c.inv_n_twiddle_precon);
    cfg_write(CFG_IDX_SPARE,                      $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ntlb_pkg::cfg_regs_t tidy_cfg(logic [31:0] q);
    ntlb_pkg::cfg_regs_t c;
    c.modulus              = q;
    c.inv_n                = $urandom % q;
    c.inv_n_precon         = quot_factor(c.inv_n, q);
    c.inv_n_twiddle        = $urandom % q;
    c.inv_n_twiddle_precon = quot_factor(c.inv_n_twiddle, q);
    return c;
  endfunction

  // tidy: operands below 4q, twiddle below q with its true quotient factor
  function automatic ntlb_pkg::req_t random_req(bit tidy);
    ntlb_pkg::req_t r;
    logic [63:0]    span;
    logic [31:0]    q;
    q = model_cfg.modulus;
    r.req_type = ($urandom_range(0, 19) == 0) ? ntlb_pkg::MODE_UNUSED
                                              : 2'($urandom_range(0, 2));
    if (tidy && q != 0) begin
      span             = {30'd0, q, 2'b00};
      r.x_in           = 34'({$urandom, $urandom} % span);
      r.y_in           = 34'({$urandom, $urandom} % span);
      r.twiddle        = $urandom % q;
      r.twiddle_precon = quot_factor(r.twiddle, q);
    end else begin
      r.x_in           = 34'({$urandom, $urandom});
      r.y_in           = 34'({$urandom, $urandom});
      r.twiddle        = $urandom;
      r.twiddle_precon = $urandom;
    end
    return r;
  endfunction

  // wait out the pipeline before touching the registers again
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // registers still at reset: q of zero, every mode and the saturated operands
  task automatic test_zero_modulus();
    ntlb_pkg::req_t r;
    for (int m = 0; m < 4; m++) begin
      r.req_type       = 2'(m);
      r.x_in           = (m[0]) ? X_MAX : '0;
      r.y_in           = X_MAX;
      r.twiddle        = '1;
      r.twiddle_precon = '1;
      send_req(r);
    end
  endtask

  // boundary operands around 2q and 4q, twiddle at 0, q-1 and all ones
  task automatic test_directed_extremes();
    ntlb_pkg::req_t r;
    logic [33:0]    q4m1, q2;
    logic [33:0]    xs[4];
    logic [33:0]    ys[4];
    logic [31:0]    tws[4];
    q2   = {1'b0, model_cfg.modulus, 1'b0};
    q4m1 = {model_cfg.modulus, 2'b00} - 34'd1;
    xs   = '{34'd0, q4m1, q2, X_MAX};
    ys   = '{34'd0, q4m1, q2 - 34'd1, 34'd0};
    tws  = '{32'd0, model_cfg.modulus - 32'd1, 32'hFFFF_FFFF, model_cfg.modulus - 32'd1};
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 4; i++) begin
        r.req_type       = 2'(m);
        r.x_in           = xs[i];
        r.y_in           = ys[i];
        r.twiddle        = tws[i];
        r.twiddle_precon = (i == 2) ? 32'hFFFF_FFFF
                                    : quot_factor(tws[i], model_cfg.modulus);
        send_req(r);
      end
    end
  endtask

  // mostly well-formed butterflies, a share of raw noise
  task automatic test_random_traffic(int unsigned beats, int unsigned snd_pct,
                                     int unsigned rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int unsigned i = 0; i < beats; i++)
      send_req(random_req($urandom_range(0, 99) < 85));
  endtask

  // sink stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++)
      send_req(random_req(1'b1));
  endtask

  // result sink: check the beat taken at this edge, then pick next out_ready
  always @(posedge clk) begin : result_check
    ntlb_pkg::rsp_t want;
    int unsigned    hold_left;
    int unsigned    hold_seen;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("beat with nothing expected", out_data.x_out, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.x_out !== want.x_out) report_mismatch("x_out", out_data.x_out, want.x_out);
        if (out_data.y_out !== want.y_out) report_mismatch("y_out", out_data.y_out, want.y_out);
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: too many cycles with no beat on any channel ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_seq
    ntlb_pkg::cfg_regs_t c;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 61;
    test_zero_modulus();
    drain_pipeline();

    // largest prime below 2^32
    apply_config(tidy_cfg(32'd4294967291));
    test_directed_extremes();
    test_random_traffic(140, 29, 61);
    drain_pipeline();

    // small NTT-friendly prime
    apply_config(tidy_cfg(32'd12289));
    test_random_traffic(140, 61, 29);
    drain_pipeline();

    // every register saturated
    c = '1;
    apply_config(c);
    test_random_traffic(140, 0, 0);
    drain_pipeline();

    apply_config(tidy_cfg(32'd3));
    test_backpressure();
    drain_pipeline();

    if (pending_rsp.size() != 0)
      report_mismatch("results never delivered", 64'(pending_rsp.size()), '0);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
src/ntlb_pkg.sv
src/ntlb_pre.sv
src/ntlb_mul.sv
src/ntlb_post.sv
src/ntt_lazy_butterfly_unit.sv
src/ntlb_checker.sv
dv/ntt_lazy_butterfly_unit_tb.sv
